// File: rtl/core/mwps_pkg.sv
// shared types, constants and wave table for the motor wave pattern sequencer
package mwps_pkg;

    localparam int MOTOR_COUNT = 8;
    localparam int DUTY_BITS   = 8;
    localparam int WAVE_LEN    = 8;
    localparam int POS_BITS    = $clog2(WAVE_LEN);
    localparam int COEF_BITS   = 17;
    localparam int COEF_SHIFT  = 16;
    localparam int MS_BITS     = 9;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 9;

    localparam logic [MS_BITS-1:0] ELAPSED_MAX = MS_BITS'(500);
    localparam logic [MS_BITS-1:0] PERIOD_MIN  = MS_BITS'(50);
    localparam logic [MS_BITS-1:0] PERIOD_MAX  = MS_BITS'(500);
    localparam logic [MS_BITS-1:0] PERIOD_RST  = MS_BITS'(100);
    localparam logic [DUTY_BITS-1:0] INTENSITY_RST = DUTY_BITS'(128);

    typedef enum logic [1:0] {
        MODE_OFF   = 2'd0,
        MODE_CONST = 2'd1,
        MODE_SINE  = 2'd2
    } t_mode;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_MODE      = 2'd0,
        CFG_INTENSITY = 2'd1,
        CFG_PERIOD    = 2'd2
    } t_cfg_idx;

    typedef logic [MOTOR_COUNT-1:0][DUTY_BITS-1:0] t_duty_vec;

    // new state handed from the core to the result register
    typedef struct packed {
        t_duty_vec           duty;
        logic [POS_BITS-1:0] wave_step;
        logic                changed;
    } t_step_res;

    // 32768 * (1 + sin(2*pi*k/8)) in unsigned q1.16, rounded
    function automatic logic [COEF_BITS-1:0] wave_coef(input logic [POS_BITS-1:0] k);
        logic [COEF_BITS-1:0] c;
        case (k)
            3'd0:    c = 17'd32768;
            3'd1:    c = 17'd55938;
            3'd2:    c = 17'd65536;
            3'd3:    c = 17'd55938;
            3'd4:    c = 17'd32768;
            3'd5:    c = 17'd9598;
            3'd6:    c = 17'd0;
            3'd7:    c = 17'd9598;
            default: c = '0;
        endcase
        return c;
    endfunction

endpackage

// File: rtl/core/motor_wave_pattern_sequencer_unit.sv
// top level of the motor wave pattern sequencer: handshake, item registers, core
// Each accepted item is one refresh of the eight motor duties, with tick high when
// one millisecond has passed. The block takes one item per clock unless the input
// stalls, and returns one result item per input item: the item lands in an input
// register, the core updates duties, wave position and the millisecond counter
// once the result register is empty or being drained, and the new state is
// captured in the result register at the end of that cycle. A stalled result holds
// the item behind it in the input register, and the input stalls only while both
// registers are full. Throughput is set by that single update step, which does the
// eight wave-table multiplies in parallel. Stop mode holds the duties (zero once
// stop is written), constant mode drives every duty to the intensity, and wave mode
// steps a sampled sine across the motors each time the elapsed count reaches the
// period. Configuration writes (mode, intensity, period) must only be issued while
// no item is in flight.
module motor_wave_pattern_sequencer_unit
    import mwps_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // input channel
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic                     i_tick,
    // configuration write port
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_wdata,
    // result channel
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic [DUTY_BITS-1:0]     o_duty_0,
    output logic [DUTY_BITS-1:0]     o_duty_1,
    output logic [DUTY_BITS-1:0]     o_duty_2,
    output logic [DUTY_BITS-1:0]     o_duty_3,
    output logic [DUTY_BITS-1:0]     o_duty_4,
    output logic [DUTY_BITS-1:0]     o_duty_5,
    output logic [DUTY_BITS-1:0]     o_duty_6,
    output logic [DUTY_BITS-1:0]     o_duty_7,
    output logic [POS_BITS-1:0]      o_wave_step,
    output logic                     o_duties_changed
);

    // input register
    logic      r_in_valid;
    logic      r_in_tick;
    // result register
    logic      r_out_valid;
    t_step_res r_out;

    logic      w_out_free;
    logic      w_step;
    logic      w_in_take;
    t_step_res w_res;

    // result register can load when empty or being drained this cycle
    assign w_out_free = !r_out_valid || !i_out_stall;
    // the item in the input register is processed when the result slot frees up
    assign w_step     = r_in_valid && w_out_free;
    // input stalls only when a held item cannot move on
    assign o_in_stall = r_in_valid && !w_out_free;
    assign w_in_take  = i_in_valid && !o_in_stall;

    mwps_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_step      (w_step),
        .i_tick      (r_in_tick),
        .o_res       (w_res)
    );

    // input register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_take) begin
            r_in_valid <= 1'b1;
        end else if (w_step) begin
            r_in_valid <= 1'b0;
        end
    end

    // input payload, no reset
    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in_tick <= i_tick;
        end
    end

    // result register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_step) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // result payload, no reset
    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out <= w_res;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_duty_0         = r_out.duty[0];
    assign o_duty_1         = r_out.duty[1];
    assign o_duty_2         = r_out.duty[2];
    assign o_duty_3         = r_out.duty[3];
    assign o_duty_4         = r_out.duty[4];
    assign o_duty_5         = r_out.duty[5];
    assign o_duty_6         = r_out.duty[6];
    assign o_duty_7         = r_out.duty[7];
    assign o_wave_step      = r_out.wave_step;
    assign o_duties_changed = r_out.changed;

`ifndef NO_ASSERTIONS
    // a held item is never dropped while the result side backs up
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_out_free) |=> (r_in_valid && $stable(r_in_tick)))
        else $error("held item lost or changed under stall");

    // every processed item shows up in the result register
    a_step_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_step |=> o_out_valid)
        else $error("processed item did not reach result register");

    // a waiting result is not overwritten
    a_out_keep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |-> !w_step)
        else $error("stalled result overwritten");
`endif

endmodule

// File: rtl/core/mwps_wave_calc.sv
// sampled sine duties for all motors at the current wave position
module mwps_wave_calc
    import mwps_pkg::*;
(
    input  logic [POS_BITS-1:0]  i_pos,
    input  logic [DUTY_BITS-1:0] i_intensity,
    output t_duty_vec            o_duty
);

    localparam int PROD_BITS = COEF_BITS + DUTY_BITS;

    always_comb begin
        logic [POS_BITS-1:0]  k;
        logic [PROD_BITS-1:0] prod;
        o_duty = '0;
        for (int i = 0; i < MOTOR_COUNT; i++) begin
            k    = POS_BITS'(i) - i_pos;
            prod = PROD_BITS'(wave_coef(k)) * PROD_BITS'(i_intensity);
            o_duty[i] = prod[COEF_SHIFT +: DUTY_BITS];
        end
    end

endmodule

// File: rtl/core/mwps_core.sv
// pattern state, configuration registers and per-item update
module mwps_core
    import mwps_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_wdata,
    input  logic                     i_step,
    input  logic                     i_tick,
    output t_step_res                o_res
);

    t_mode                r_mode;
    logic [DUTY_BITS-1:0] r_intensity;
    logic [MS_BITS-1:0]   r_period;
    t_duty_vec            r_duty;
    logic [POS_BITS-1:0]  r_pos;
    logic [MS_BITS-1:0]   r_elapsed;

    t_duty_vec            n_duty;
    logic [POS_BITS-1:0]  n_pos;
    logic [MS_BITS-1:0]   n_elapsed;
    logic                 n_changed;
    t_duty_vec            w_wave_duty;
    logic [MS_BITS-1:0]   w_period_in;

    mwps_wave_calc u_wave (
        .i_pos       (r_pos),
        .i_intensity (r_intensity),
        .o_duty      (w_wave_duty)
    );

    assign w_period_in = i_cfg_wdata[MS_BITS-1:0];

    always_comb begin
        n_duty    = r_duty;
        n_pos     = r_pos;
        n_changed = 1'b0;
        n_elapsed = r_elapsed;
        if (i_tick && (r_elapsed < ELAPSED_MAX)) begin
            n_elapsed = r_elapsed + MS_BITS'(1);
        end
        case (r_mode)
            MODE_CONST: begin
                for (int i = 0; i < MOTOR_COUNT; i++) begin
                    if (r_duty[i] != r_intensity) begin
                        n_changed = 1'b1;
                    end
                    n_duty[i] = r_intensity;
                end
            end
            MODE_SINE: begin
                if (n_elapsed >= r_period) begin
                    n_elapsed = '0;
                    n_duty    = w_wave_duty;
                    n_changed = 1'b1;
                    n_pos     = r_pos + POS_BITS'(1);
                end
            end
            default: begin
            end
        endcase
    end

    assign o_res.duty      = n_duty;
    assign o_res.wave_step = n_pos;
    assign o_res.changed   = n_changed;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_OFF;
            r_intensity <= INTENSITY_RST;
            r_period    <= PERIOD_RST;
            r_duty      <= '0;
            r_pos       <= '0;
            r_elapsed   <= '0;
        end else begin
            if (i_step) begin
                r_duty    <= n_duty;
                r_pos     <= n_pos;
                r_elapsed <= n_elapsed;
            end
            // the user must issue writes only while no item is in flight; the core does not enforce it
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_MODE: begin
                        case (i_cfg_wdata[1:0])
                            MODE_OFF: begin
                                r_mode <= MODE_OFF;
                                r_duty <= '0;
                            end
                            MODE_CONST: begin
                                r_mode <= MODE_CONST;
                            end
                            MODE_SINE: begin
                                r_mode <= MODE_SINE;
                                r_pos  <= '0;
                            end
                            default: begin
                            end
                        endcase
                    end
                    CFG_INTENSITY: begin
                        r_intensity <= i_cfg_wdata[DUTY_BITS-1:0];
                    end
                    CFG_PERIOD: begin
                        if ((w_period_in >= PERIOD_MIN) && (w_period_in <= PERIOD_MAX)) begin
                            r_period <= w_period_in;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

endmodule

// File: dv/testbench.sv
// self-checking testbench for the motor wave pattern sequencer
module testbench;
    import mwps_pkg::*;

    localparam logic [1:0]              MODE_UNUSED = 2'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_UNUSED  = 2'd3;
    localparam logic [8:0]              MS_CAP      = 9'd500;
    localparam logic [8:0]              PERIOD_LO   = 9'd50;
    localparam logic [8:0]              PERIOD_HI   = 9'd500;

    // one raised sine period over eight positions, unsigned q1.16
    localparam logic [16:0] SINE_Q16 [8] = '{
        17'd32768, 17'd55938, 17'd65536, 17'd55938,
        17'd32768, 17'd9598,  17'd0,     17'd9598
    };

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_ALTERNATE
    } t_stall_style;

    logic                     i_clk       = 1'b0;
    logic                     i_rst_n     = 1'b0;
    logic                     i_in_valid  = 1'b0;
    logic                     i_tick      = 1'b0;
    logic                     i_cfg_we    = 1'b0;
    logic [CFG_IDX_BITS-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] i_cfg_wdata = '0;
    logic                     i_out_stall = 1'b0;
    logic                     o_in_stall;
    logic                     o_out_valid;
    logic [DUTY_BITS-1:0]     o_duty_0, o_duty_1, o_duty_2, o_duty_3;
    logic [DUTY_BITS-1:0]     o_duty_4, o_duty_5, o_duty_6, o_duty_7;
    logic [POS_BITS-1:0]      o_wave_step;
    logic                     o_duties_changed;

    motor_wave_pattern_sequencer_unit i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_tick           (i_tick),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_wdata      (i_cfg_wdata),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_duty_0         (o_duty_0),
        .o_duty_1         (o_duty_1),
        .o_duty_2         (o_duty_2),
        .o_duty_3         (o_duty_3),
        .o_duty_4         (o_duty_4),
        .o_duty_5         (o_duty_5),
        .o_duty_6         (o_duty_6),
        .o_duty_7         (o_duty_7),
        .o_wave_step      (o_wave_step),
        .o_duties_changed (o_duties_changed)
    );

    always #5 i_clk = ~i_clk;

    // shadow copy of the sequencer state
    t_mode                 mdl_mode      = MODE_OFF;
    logic [DUTY_BITS-1:0]  mdl_intensity = 8'd128;
    logic [8:0]            mdl_period    = 9'd100;
    t_duty_vec             mdl_duty      = '0;
    logic [POS_BITS-1:0]   mdl_pos       = '0;
    logic [8:0]            mdl_elapsed   = '0;

    logic      tick_q[$];           // refresh items waiting to be sent
    t_step_res duty_frames_due[$];  // predicted duty frames, oldest first
    logic      item_taken = 1'b0;
    int        burst_left = 0;
    int        gap_left   = 0;
    int        items_sent = 0;
    int        frames_checked = 0;
    int        wave_steps = 0;
    int        reg_writes = 0;
    int        mismatches = 0;
    t_stall_style stall_style = STALL_NONE;
    int        stall_run = 0;
    logic      stall_toggle = 1'b0;

    // one refresh: advance the ms counter, then apply the active pattern
    function automatic t_step_res refresh_motors(input logic tick);
        t_step_res            frame;
        logic [POS_BITS-1:0]  k;
        logic [24:0]          prod;
        frame.changed = 1'b0;
        if (tick && mdl_elapsed < MS_CAP)
            mdl_elapsed = mdl_elapsed + 9'd1;
        if (mdl_mode == MODE_CONST) begin
            for (int m = 0; m < MOTOR_COUNT; m++) begin
                if (mdl_duty[m] != mdl_intensity) begin
                    mdl_duty[m] = mdl_intensity;
                    frame.changed = 1'b1;
                end
            end
        end else if (mdl_mode == MODE_SINE && mdl_elapsed >= mdl_period) begin
            mdl_elapsed = '0;
            for (int m = 0; m < MOTOR_COUNT; m++) begin
                k = POS_BITS'(m) - mdl_pos;
                prod = SINE_Q16[k] * mdl_intensity;
                mdl_duty[m] = prod[23:16];
            end
            frame.changed = 1'b1;
            mdl_pos = mdl_pos + 1'b1;
            wave_steps++;
        end
        frame.duty = mdl_duty;
        frame.wave_step = mdl_pos;
        return frame;
    endfunction

    task automatic note_mismatch(input string what, input int unsigned want,
                                 input int unsigned got);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch on %s: expected %0d, got %0d", what, want, got);
    endtask

    // register write at the next clock, mirrored into the shadow state
    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        case (idx)
            CFG_MODE: begin
                case (data[1:0])
                    MODE_OFF: begin
                        mdl_mode = MODE_OFF;
                        mdl_duty = '0;
                    end
                    MODE_CONST: mdl_mode = MODE_CONST;
                    MODE_SINE: begin
                        mdl_mode = MODE_SINE;
                        mdl_pos  = '0;
                    end
                    default: ;  // unused code leaves the mode alone
                endcase
            end
            CFG_INTENSITY: mdl_intensity = data[7:0];
            CFG_PERIOD: begin
                if (data >= PERIOD_LO && data <= PERIOD_HI)
                    mdl_period = data;
            end
            default: ;
        endcase
        reg_writes++;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // nothing queued, nothing on the wire, nothing owed
    task automatic wait_idle;
        do
            @(posedge i_clk);
        while (tick_q.size() != 0 || i_in_valid || duty_frames_due.size() != 0);
    endtask

    task automatic send_ticks(input int count, input int pct_tick);
        repeat (count) tick_q.push_back($urandom_range(0, 99) < pct_tick);
        wait_idle();
    endtask

    // sender: bursts of items separated by random gaps, payload held while stalled
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_in_valid || item_taken)) begin
            item_taken = 1'b0;
            if (gap_left != 0) begin
                gap_left--;
                i_in_valid <= 1'b0;
            end else if (tick_q.size() != 0) begin
                i_in_valid <= 1'b1;
                i_tick     <= tick_q.pop_front();
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end else begin
                    burst_left--;
                end
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // receiver: stall style is picked at random and held for a random run
    always @(negedge i_clk) begin
        if (stall_run == 0) begin
            stall_style = t_stall_style'($urandom_range(0, 3));
            stall_run   = $urandom_range(20, 200);
        end else begin
            stall_run--;
        end
        stall_toggle = ~stall_toggle;
        case (stall_style)
            STALL_NONE:   i_out_stall <= 1'b0;
            STALL_LIGHT:  i_out_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY:  i_out_stall <= ($urandom_range(0, 9) < 7);
            default:      i_out_stall <= stall_toggle;
        endcase
    end

    // monitor: check results first, then predict the item taken at this edge
    always @(posedge i_clk) begin : monitor
        t_step_res want;
        t_duty_vec got;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                got = {o_duty_7, o_duty_6, o_duty_5, o_duty_4,
                       o_duty_3, o_duty_2, o_duty_1, o_duty_0};
                if (duty_frames_due.size() == 0) begin
                    note_mismatch("result with nothing expected", 0, 1);
                end else begin
                    want = duty_frames_due.pop_front();
                    for (int m = 0; m < MOTOR_COUNT; m++)
                        if (got[m] !== want.duty[m])
                            note_mismatch($sformatf("duty_%0d", m), want.duty[m], got[m]);
                    if (o_wave_step !== want.wave_step)
                        note_mismatch("wave_step", want.wave_step, o_wave_step);
                    if (o_duties_changed !== want.changed)
                        note_mismatch("duties_changed", want.changed, o_duties_changed);
                end
                frames_checked++;
            end
            if (i_in_valid && !o_in_stall) begin
                duty_frames_due.push_back(refresh_motors(i_tick));
                items_sent++;
                item_taken = 1'b1;
            end
        end
    end

    initial begin : stimulus
        int pick;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset state in stop mode, with and without time passing
        tick_q.push_back(1'b0);
        tick_q.push_back(1'b1);
        tick_q.push_back(1'b1);
        tick_q.push_back(1'b0);
        wait_idle();
        write_reg(CFG_MODE, 9'(MODE_OFF));   // stop again while already stopped
        send_ticks(1, 50);
        write_reg(CFG_MODE, 9'(MODE_CONST)); // first refresh changes, second does not
        send_ticks(2, 50);
        write_reg(CFG_INTENSITY, 9'd255);
        send_ticks(1, 50);
        write_reg(CFG_INTENSITY, 9'h100);    // bit 8 is dropped, intensity zero
        send_ticks(1, 50);
        write_reg(CFG_INTENSITY, 9'h1AA);
        send_ticks(1, 50);
        write_reg(CFG_MODE, 9'(MODE_UNUSED)); // ignored, stays constant
        write_reg(CFG_UNUSED, 9'h1FF);        // no such register
        send_ticks(1, 50);
        // periods outside the legal range must not stick
        write_reg(CFG_PERIOD, 9'd49);
        write_reg(CFG_PERIOD, 9'd501);
        write_reg(CFG_PERIOD, 9'd511);
        write_reg(CFG_PERIOD, 9'd0);
        write_reg(CFG_PERIOD, 9'd50);
        write_reg(CFG_MODE, 9'h1FE);          // wave, upper bits ignored
        send_ticks(2, 100);
        write_reg(CFG_MODE, 9'h1FC);          // stop clears the wave duties
        send_ticks(1, 100);

        // long stop stretch saturates the ms counter
        send_ticks(505, 100);
        // saturated counter against the longest period: step on the first refresh
        write_reg(CFG_PERIOD, 9'd500);
        write_reg(CFG_INTENSITY, 9'd255);
        write_reg(CFG_MODE, 9'(MODE_SINE));
        send_ticks(30, 90);
        // shortest period, long enough for the position to wrap
        write_reg(CFG_PERIOD, 9'd50);
        send_ticks(410, 100);
        // re-entering wave restarts the position, zero intensity
        write_reg(CFG_INTENSITY, 9'd0);
        write_reg(CFG_MODE, 9'(MODE_SINE));
        send_ticks(40, 97);

        // random settings between phases
        repeat (4) begin
            if ($urandom_range(0, 9) < 6) begin
                pick = $urandom_range(0, 9);
                if (pick < 2)
                    write_reg(CFG_MODE, {7'($urandom), MODE_OFF});
                else if (pick < 4)
                    write_reg(CFG_MODE, {7'($urandom), MODE_CONST});
                else if (pick < 9)
                    write_reg(CFG_MODE, {7'($urandom), MODE_SINE});
                else
                    write_reg(CFG_MODE, {7'($urandom), MODE_UNUSED});
            end
            if ($urandom_range(0, 1) == 1) begin
                pick = $urandom_range(0, 3);
                if (pick == 0)
                    write_reg(CFG_INTENSITY, 9'd0);
                else if (pick == 1)
                    write_reg(CFG_INTENSITY, 9'd255);
                else
                    write_reg(CFG_INTENSITY, 9'($urandom));
            end
            if ($urandom_range(0, 1) == 1) begin
                pick = $urandom_range(0, 9);
                if (pick < 7)
                    write_reg(CFG_PERIOD, 9'($urandom_range(50, 64)));
                else if (pick == 7)
                    write_reg(CFG_PERIOD, 9'd500);
                else
                    write_reg(CFG_PERIOD, 9'($urandom));
            end
            if ($urandom_range(0, 7) == 0)
                write_reg(CFG_UNUSED, 9'($urandom));
            send_ticks($urandom_range(15, 35), 85);
        end

        wait_idle();
        repeat (4) @(posedge i_clk);
        $display("ran %0d refresh items, checked %0d duty frames, %0d of them wave steps",
                 items_sent, frames_checked, wave_steps);
        $display("%0d register writes, %0d mismatches", reg_writes, mismatches);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // watchdog against a hung handshake
    initial begin
        #2000000;
        $display("timeout waiting for the sequencer");
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// File: motor_wave_pattern_sequencer_unit.f
rtl/core/mwps_pkg.sv
rtl/core/mwps_wave_calc.sv
rtl/core/mwps_core.sv
rtl/core/motor_wave_pattern_sequencer_unit.sv
dv/testbench.sv
